FILE: rtl/constant_accel_travel_time_macros.svh
// Assertion macros for the constant-acceleration travel time block.
`ifndef CONSTANT_ACCEL_TRAVEL_TIME_MACROS_SVH
`define CONSTANT_ACCEL_TRAVEL_TIME_MACROS_SVH
`ifndef SYNTH
`define CATT_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CATT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CATT_ASSERT_IMPL(label, clk, rst, prop, msg)
`define CATT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/catt_pkg.sv
// Shared types and constants for the travel time block.
package catt_pkg;
  localparam int QShift = 16;
  localparam int SqrtSteps = 32;
  localparam int DivSteps = 64;
  localparam logic [15:0] EpsReset = 16'd1;
  localparam logic [31:0] TimeMax = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_LINEAR  = 2'd0,
    MODE_ACCEL   = 2'd1,
    MODE_BRAKE   = 2'd2,
    MODE_REVERSE = 2'd3
  } mode_t;

  typedef struct packed {
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic [30:0] distance;
  } in_item_t;

  typedef struct packed {
    logic [31:0] travel_time;
    logic saturated;
  } out_item_t;

  // Data handed down the square root chain.
  typedef struct packed {
    logic valid;
    mode_t mode;
    logic [63:0] rad;
    logic [63:0] rem;
    logic [31:0] root;
    logic [31:0] vm;
    logic [31:0] am;
    logic [30:0] dm;
  } sq_tok_t;

  // Data handed down the divider chain.
  typedef struct packed {
    logic valid;
    logic [63:0] num;
    logic [32:0] den;
    logic [33:0] rem;
    logic [63:0] quo;
  } dv_tok_t;
endpackage

FILE: rtl/constant_accel_travel_time.sv
// Top level: constant acceleration travel time, square root and divider cell chains.
// Stages: 1 front stage, 32 root cells, 1 select stage, 64 divider cells, 1 output
// register; the front stage loads at the input transfer edge.
// Throughput: one item per cycle; the whole chain advances unless the output is held.
// Reset (rst, synchronous): clears all valid bits and sets near_zero_threshold to EpsInit (default 1).
// Payload registers are not reset.
module constant_accel_travel_time #(
  parameter logic [15:0] EpsInit = catt_pkg::EpsReset
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic in_valid,
  output logic in_ready,
  input  catt_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output catt_pkg::out_item_t out_data
);
`include "constant_accel_travel_time_macros.svh"

  localparam int NS = catt_pkg::SqrtSteps;
  localparam int ND = catt_pkg::DivSteps;

  // Configuration register; only address 0 holds a register.
  logic [15:0] near_zero_threshold;
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {16'd0, near_zero_threshold} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      near_zero_threshold <= EpsInit;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      near_zero_threshold <= pwdata[15:0];
    end
  end

  // Whole chain moves together; stalls only when the output register is full
  // and not being drained.
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // Front stage: magnitudes, mode select and radicand.
  logic [31:0] vm_c, am_c, eps_c;
  logic vneg, aneg, opp;
  logic [63:0] vv, tad;
  catt_pkg::sq_tok_t front;
  catt_pkg::sq_tok_t sq [NS+1];

  always_comb begin
    vneg = in_data.velocity[31];
    aneg = in_data.acceleration[31];
    vm_c = vneg ? 32'(-in_data.velocity) : in_data.velocity;
    am_c = aneg ? 32'(-in_data.acceleration) : in_data.acceleration;
    eps_c = {16'd0, (near_zero_threshold == 16'd0) ? 16'd1 : near_zero_threshold};
    opp = (vm_c != 32'd0) && (vneg != aneg);
    vv = 64'(vm_c) * 64'(vm_c);
    tad = 64'(am_c) * 64'({in_data.distance, 1'b0});
    front.valid = in_valid;
    front.vm = vm_c;
    front.am = am_c;
    front.dm = in_data.distance;
    front.rem = 64'd0;
    front.root = 32'd0;
    if (am_c < eps_c) begin
      front.mode = catt_pkg::MODE_LINEAR;
      front.am = (vm_c < eps_c) ? eps_c : vm_c;
      front.rad = 64'd0;
    end else if (!opp) begin
      front.mode = catt_pkg::MODE_ACCEL;
      front.rad = vv + tad;
    end else if (vv >= tad) begin
      front.mode = catt_pkg::MODE_BRAKE;
      front.rad = vv - tad;
    end else begin
      front.mode = catt_pkg::MODE_REVERSE;
      front.rad = vv + tad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].valid <= 1'b0;
    end else if (en) begin
      sq[0].valid <= front.valid;
    end
    if (en) begin
      sq[0].mode <= front.mode;
      sq[0].rad <= front.rad;
      sq[0].rem <= front.rem;
      sq[0].root <= front.root;
      sq[0].vm <= front.vm;
      sq[0].am <= front.am;
      sq[0].dm <= front.dm;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_sq
    catt_sqrt_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .din(sq[i]), .dout(sq[i+1])
    );
  end

  // Select stage: numerator and denominator per mode.
  catt_pkg::sq_tok_t sl;
  catt_pkg::dv_tok_t dfront;
  catt_pkg::dv_tok_t dv [ND+1];
  assign sl = sq[NS];
  always_comb begin
    dfront.valid = sl.valid;
    dfront.rem = 34'd0;
    dfront.quo = 64'd0;
    unique case (sl.mode)
      catt_pkg::MODE_LINEAR: begin
        dfront.num = {17'd0, sl.dm, 16'd0};
        dfront.den = {1'b0, sl.am};
      end
      catt_pkg::MODE_ACCEL, catt_pkg::MODE_BRAKE: begin
        dfront.num = {16'd0, sl.dm, 17'd0};
        dfront.den = 33'(sl.root) + 33'(sl.vm);
      end
      default: begin
        dfront.num = {16'd0, sl.root, 16'd0};
        dfront.den = {1'b0, sl.am};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else if (en) begin
      dv[0].valid <= dfront.valid;
    end
    if (en) begin
      dv[0].num <= dfront.num;
      dv[0].den <= dfront.den;
      dv[0].rem <= dfront.rem;
      dv[0].quo <= dfront.quo;
    end
  end

  for (genvar j = 0; j < ND; j++) begin : g_dv
    catt_div_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .din(dv[j]), .dout(dv[j+1])
    );
  end

  // Output register: zero denominator gives zero, otherwise saturate to 32 bits.
  catt_pkg::dv_tok_t dl;
  catt_pkg::out_item_t res;
  assign dl = dv[ND];
  always_comb begin
    if (dl.den == 33'd0) begin
      res.travel_time = 32'd0;
      res.saturated = 1'b0;
    end else if (dl.quo[63:32] != 32'd0) begin
      res.travel_time = catt_pkg::TimeMax;
      res.saturated = 1'b1;
    end else begin
      res.travel_time = dl.quo[31:0];
      res.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dl.valid;
    end
    if (en) begin
      out_data <= res;
    end
  end

  // Saturation flag always pairs with the clipped maximum.
  `CATT_ASSERT_IMPL(a_sat_max, clk, rst, (out_valid && out_data.saturated) |-> (out_data.travel_time == catt_pkg::TimeMax), "saturated without max time")
  // A held result stays put.
  `CATT_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  // Ready drops whenever the output register is held.
  `CATT_ASSERT_IMPL(a_ready, clk, rst, (out_valid && !out_ready) |-> !in_ready, "input taken while chain stalled")
endmodule

FILE: rtl/catt_sqrt_cell.sv
// One restoring square root step: settles one root bit per cell.
module catt_sqrt_cell (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  catt_pkg::sq_tok_t din,
  output catt_pkg::sq_tok_t dout
);
  logic [65:0] trial;
  logic [65:0] remsh;
  catt_pkg::sq_tok_t nx;

  always_comb begin
    nx = din;
    remsh = {din.rem, din.rad[63:62]};
    trial = {32'd0, din.root, 2'b01};
    nx.rad = {din.rad[61:0], 2'b00};
    if (remsh >= trial) begin
      nx.rem = 64'(remsh - trial);
      nx.root = {din.root[30:0], 1'b1};
    end else begin
      nx.rem = remsh[63:0];
      nx.root = {din.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.mode <= nx.mode;
      dout.rad <= nx.rad;
      dout.rem <= nx.rem;
      dout.root <= nx.root;
      dout.vm <= nx.vm;
      dout.am <= nx.am;
      dout.dm <= nx.dm;
    end
  end
endmodule

FILE: rtl/catt_div_cell.sv
// One restoring division step: settles one quotient bit per cell.
module catt_div_cell (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  catt_pkg::dv_tok_t din,
  output catt_pkg::dv_tok_t dout
);
  logic [33:0] sh;
  catt_pkg::dv_tok_t nx;

  always_comb begin
    nx = din;
    sh = {din.rem[32:0], din.num[63]};
    nx.num = {din.num[62:0], 1'b0};
    if (sh >= {1'b0, din.den}) begin
      nx.rem = sh - {1'b0, din.den};
      nx.quo = {din.quo[62:0], 1'b1};
    end else begin
      nx.rem = sh;
      nx.quo = {din.quo[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.num <= nx.num;
      dout.den <= nx.den;
      dout.rem <= nx.rem;
      dout.quo <= nx.quo;
    end
  end
endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the constant acceleration travel time block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 98;
  localparam int WatchdogLimit = 4000;
  localparam logic [1:0] AddrThreshold = 2'd0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  catt_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  catt_pkg::out_item_t out_data;

  // Predictor copy of the threshold register.
  logic [15:0] eps_reg = catt_pkg::EpsReset;
  catt_pkg::out_item_t time_queue[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  // Directed rows: the expected time is typed in where it is obvious.
  typedef struct {
    logic signed [31:0] v;
    logic signed [31:0] a;
    logic [30:0] d;
    bit has_exp;
    logic [31:0] t;
    logic sat;
  } row_t;

  constant_accel_travel_time u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] div0(logic [63:0] n, logic [63:0] q);
    return (q == 0) ? 64'd0 : n / q;
  endfunction

  // Travel time under constant acceleration, from the current threshold.
  function automatic catt_pkg::out_item_t travel_time_of(catt_pkg::in_item_t it);
    logic [63:0] vm, am, dm, e, vv, two_ad, t;
    bit vneg, aneg, opposing;
    catt_pkg::out_item_t r;
    vneg = it.velocity[31];
    aneg = it.acceleration[31];
    vm = vneg ? 64'h1_0000_0000 - {32'd0, it.velocity} : {32'd0, it.velocity};
    am = aneg ? 64'h1_0000_0000 - {32'd0, it.acceleration} : {32'd0, it.acceleration};
    dm = {33'd0, it.distance};
    e = (eps_reg == 0) ? 64'd1 : {48'd0, eps_reg};
    if (am < e) begin
      t = div0(dm << 16, (vm < e) ? e : vm);
    end else begin
      vv = vm * vm;
      two_ad = 2 * am * dm;
      opposing = (vm != 0) && (vneg != aneg);
      if (!opposing)
        t = div0(dm << 17, isqrt64(vv + two_ad) + vm);
      else if (vv >= two_ad)
        t = div0(dm << 17, vm + isqrt64(vv - two_ad));
      else
        t = div0(isqrt64(vv + two_ad) << 16, am);
    end
    r.saturated = (t > 64'hFFFF_FFFF);
    r.travel_time = r.saturated ? catt_pkg::TimeMax : t[31:0];
    return r;
  endfunction

  // APB write: setup then access; only called while the block is idle.
  task automatic write_threshold(logic [15:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= AddrThreshold; pwdata <= {16'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    eps_reg = val;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(catt_pkg::in_item_t it);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    time_queue.push_back(travel_time_of(it));
    @(negedge clk);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (time_queue.size() != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_signed32();
    case ($urandom_range(0, 4))
      0: return $signed($urandom);
      1: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      2: return $signed({$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)});
      3: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 8)) - 32'sd4;
    endcase
  endfunction

  function automatic logic [30:0] rand_distance();
    case ($urandom_range(0, 3))
      0: return 31'($urandom);
      1: return 31'($urandom_range(0, 32'h0010_0000));
      2: return 31'($urandom_range(0, 16));
      default: return 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
    endcase
  endfunction

  // Receiver: random stalls plus one long hold-off to fill the chain.
  always @(negedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 7) <= 4) || ($urandom_range(0, 3) == 0);
  end

  initial begin
    @(negedge rst);
    repeat (300) @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  // Check each output transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (time_queue.size() == 0) begin
        $error("unexpected output transfer: travel_time %0h", out_data.travel_time);
        errors++;
      end else begin
        catt_pkg::out_item_t exp_r;
        exp_r = time_queue.pop_front();
        if (out_data.travel_time !== exp_r.travel_time) begin
          $error("travel_time expected %0h actual %0h",
                 exp_r.travel_time, out_data.travel_time);
          errors++;
        end
        if (out_data.saturated !== exp_r.saturated) begin
          $error("saturated expected %0b actual %0b", exp_r.saturated, out_data.saturated);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no transfer on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else if (in_valid || time_queue.size() != 0) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    catt_pkg::out_item_t got;
    catt_pkg::in_item_t it;
    logic [15:0] eps_list[6];
    rows = '{
      // zero distance, zero everything
      '{32'sd0, 32'sd0, 31'd0, 1, 32'd0, 1'b0},
      // coasting at 1.0 over 1.0
      '{32'sh0001_0000, 32'sd0, 31'h0001_0000, 1, 32'h0001_0000, 1'b0},
      // standing still, no accel: floor at eps=1 saturates
      '{32'sd0, 32'sd0, 31'h7FFF_FFFF, 1, catt_pkg::TimeMax, 1'b1},
      '{32'sh7FFF_FFFF, 32'sd0, 31'h7FFF_FFFF, 0, 0, 0},
      '{32'sh8000_0000, 32'sd0, 31'h7FFF_FFFF, 0, 0, 0},
      // speeding up, both signs
      '{32'sh0001_0000, 32'sh0001_0000, 31'h0004_0000, 0, 0, 0},
      '{-32'sh0001_0000, -32'sh0002_0000, 31'h0004_0000, 0, 0, 0},
      // from rest with accel
      '{32'sd0, 32'sh0002_0000, 31'h0001_0000, 0, 0, 0},
      '{32'sd0, 32'sh8000_0000, 31'h7FFF_FFFF, 0, 0, 0},
      // braking, arrives before stopping
      '{32'sh0010_0000, -32'sh0001_0000, 31'h0001_0000, 0, 0, 0},
      // braking exactly to a stop
      '{32'sh0002_0000, -32'sh0001_0000, 31'h0002_0000, 0, 0, 0},
      // stops and reverses
      '{32'sh0001_0000, -32'sh0001_0000, 31'h0010_0000, 0, 0, 0},
      '{-32'sh0001_0000, 32'sh0001_0000, 31'h0010_0000, 0, 0, 0},
      '{32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 0, 0, 0},
      '{32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 0, 0, 0},
      // opposing with zero distance
      '{32'sh0001_0000, -32'sh0001_0000, 31'd0, 1, 32'd0, 1'b0},
      '{32'sd1, 32'sd1, 31'd1, 0, 0, 0},
      '{-32'sd1, 32'sd1, 31'd1, 0, 0, 0}
    };
    eps_list = '{16'd0, 16'hFFFF, 16'd1, 16'h0100, 16'h8000, 16'h0010};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_threshold(16'd1);
    foreach (rows[i]) begin
      rw = rows[i];
      it.velocity = rw.v;
      it.acceleration = rw.a;
      it.distance = rw.d;
      if (rw.has_exp) begin
        got = travel_time_of(it);
        if (got.travel_time !== rw.t || got.saturated !== rw.sat) begin
          $error("directed row %0d: travel_time expected %0h predicted %0h",
                 i, rw.t, got.travel_time);
          errors++;
        end
      end
      send_item(it);
    end
    // Random phases, each under its own threshold setting.
    foreach (eps_list[p]) begin
      drain_block();
      write_threshold(eps_list[p]);
      repeat (90) begin
        it.velocity = rand_signed32();
        it.acceleration = rand_signed32();
        it.distance = rand_distance();
        if ($urandom_range(0, 5) == 0)
          it.acceleration = $signed(32'($urandom_range(0, 2 * eps_list[p]))) -
                            $signed(32'(eps_list[p]));
        send_item(it);
      end
    end
    drain_block();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/catt_pkg.sv
rtl/catt_sqrt_cell.sv
rtl/catt_div_cell.sv
rtl/constant_accel_travel_time.sv
tb/testbench.sv
